>>> rtl/acc_pkg.sv
// Shared types, reset values and helper functions for the alarm clock controller.
package acc_pkg;

  localparam logic [4:0] HOUR_MAX       = 5'd23;
  localparam logic [5:0] MINUTE_MAX     = 6'd59;
  localparam logic [5:0] SECOND_MAX     = 6'd59;

  localparam logic [4:0] HOUR_RESET     = 5'd19;
  localparam logic [5:0] MINUTE_RESET   = 6'd54;
  localparam logic [5:0] SECOND_RESET   = 6'd0;
  localparam logic [4:0] ALARM_H_RESET  = 5'd19;
  localparam logic [5:0] ALARM_M_RESET  = 6'd55;
  localparam logic [4:0] SAVED_H_RESET  = 5'd10;
  localparam logic [5:0] SAVED_M_RESET  = 6'd0;

  typedef struct packed {
    logic second_tick;
    logic up_button;
    logic down_button;
    logic set_button;
    logic enable_button;
  } acc_in_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] seg_hour_tens;
    logic [6:0] seg_hour_ones;
    logic [6:0] seg_minute_tens;
    logic [6:0] seg_minute_ones;
    logic [3:0] point_bits;
    logic       alarm_armed;
    logic       setting_alarm;
    logic       alarm_match;
  } acc_out_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } acc_time_t;

  typedef struct packed {
    acc_time_t  shown;
    logic [5:0] seconds;
    logic       armed;
    logic       editing;
    logic       match;
  } acc_status_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } acc_digits_t;

  function automatic acc_time_t minute_up(input acc_time_t t);
    acc_time_t r;
    r = t;
    if (t.minute < MINUTE_MAX) begin
      r.minute = t.minute + 6'd1;
    end else if (t.hour < HOUR_MAX) begin
      r.hour   = t.hour + 5'd1;
      r.minute = 6'd0;
    end else begin
      r.hour   = 5'd0;
      r.minute = 6'd0;
    end
    return r;
  endfunction

  function automatic acc_time_t minute_down(input acc_time_t t);
    acc_time_t r;
    r = t;
    if (t.minute != 6'd0) begin
      r.minute = t.minute - 6'd1;
    end else if (t.hour != 5'd0) begin
      r.hour   = t.hour - 5'd1;
      r.minute = MINUTE_MAX;
    end else begin
      r.hour   = HOUR_MAX;
      r.minute = MINUTE_MAX;
    end
    return r;
  endfunction

  function automatic acc_digits_t dec_split(input logic [5:0] v);
    acc_digits_t d;
    if (v >= 6'd60) begin
      d.tens = 3'd6;
      d.ones = 4'(v - 6'd60);
    end else if (v >= 6'd50) begin
      d.tens = 3'd5;
      d.ones = 4'(v - 6'd50);
    end else if (v >= 6'd40) begin
      d.tens = 3'd4;
      d.ones = 4'(v - 6'd40);
    end else if (v >= 6'd30) begin
      d.tens = 3'd3;
      d.ones = 4'(v - 6'd30);
    end else if (v >= 6'd20) begin
      d.tens = 3'd2;
      d.ones = 4'(v - 6'd20);
    end else if (v >= 6'd10) begin
      d.tens = 3'd1;
      d.ones = 4'(v - 6'd10);
    end else begin
      d.tens = 3'd0;
      d.ones = v[3:0];
    end
    return d;
  endfunction

  function automatic logic [6:0] seg_lit(input logic [3:0] digit);
    logic [6:0] s;
    case (digit)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/acc_if.sv
// Valid/ready channel interfaces for input words and result words.
interface acc_in_if;
  import acc_pkg::*;
  logic    valid;
  logic    ready;
  acc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acc_out_if;
  import acc_pkg::*;
  logic     valid;
  logic     ready;
  acc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/acc_core.sv
// Clock state registers and the per-word time, alarm and mode update.
module acc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  acc_pkg::acc_in_t    word,
  output acc_pkg::acc_status_t status
);
  import acc_pkg::*;

  acc_time_t  shown;
  logic [5:0] seconds;
  acc_time_t  alarm;
  acc_time_t  saved;
  logic       armed;
  logic       editing;

  acc_time_t  shown_next;
  acc_time_t  alarm_next;
  acc_time_t  saved_next;
  logic [5:0] seconds_next;
  logic       armed_next;
  logic       editing_next;
  acc_time_t  ticked;
  logic       match;

  always_comb begin
    ticked       = shown;
    seconds_next = seconds;
    if (word.second_tick) begin
      if (seconds < SECOND_MAX) begin
        seconds_next = seconds + 6'd1;
      end else begin
        seconds_next = 6'd0;
        ticked       = minute_up(shown);
      end
    end

    match = armed && (ticked == alarm) && (seconds_next == 6'd0);
    armed_next = armed ^ word.enable_button;

    alarm_next   = alarm;
    saved_next   = saved;
    editing_next = editing;
    shown_next   = ticked;
    if (word.set_button) begin
      if (!editing) begin
        saved_next   = ticked;
        shown_next   = alarm;
        editing_next = 1'b1;
      end else begin
        alarm_next   = ticked;
        shown_next   = saved;
        editing_next = 1'b0;
      end
    end else if (word.up_button) begin
      shown_next = minute_up(ticked);
    end else if (word.down_button) begin
      shown_next = minute_down(ticked);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown   <= '{hour: HOUR_RESET, minute: MINUTE_RESET};
      seconds <= SECOND_RESET;
      alarm   <= '{hour: ALARM_H_RESET, minute: ALARM_M_RESET};
      saved   <= '{hour: SAVED_H_RESET, minute: SAVED_M_RESET};
      armed   <= 1'b0;
      editing <= 1'b0;
    end else if (step) begin
      shown   <= shown_next;
      seconds <= seconds_next;
      alarm   <= alarm_next;
      saved   <= saved_next;
      armed   <= armed_next;
      editing <= editing_next;
    end
  end

  assign status = '{shown: shown_next, seconds: seconds_next, armed: armed_next,
                    editing: editing_next, match: match};

endmodule

>>> rtl/acc_display.sv
// Decimal split, active-low segment codes and decimal points for the shown time.
module acc_display (
  input  acc_pkg::acc_status_t status,
  output acc_pkg::acc_out_t    word
);
  import acc_pkg::*;

  acc_digits_t hour_dig;
  acc_digits_t minute_dig;

  always_comb begin
    hour_dig   = dec_split({1'b0, status.shown.hour});
    minute_dig = dec_split(status.shown.minute);

    word.hours           = status.shown.hour;
    word.minutes         = status.shown.minute;
    word.seconds         = status.seconds;
    word.seg_hour_tens   = ~seg_lit({1'b0, hour_dig.tens});
    word.seg_hour_ones   = ~seg_lit(hour_dig.ones);
    word.seg_minute_tens = ~seg_lit({1'b0, minute_dig.tens});
    word.seg_minute_ones = ~seg_lit(minute_dig.ones);
    word.point_bits      = {~status.armed, 1'b1, 1'b0, 1'b1};
    word.alarm_armed     = status.armed;
    word.setting_alarm   = status.editing;
    word.alarm_match     = status.match;
  end

endmodule

>>> rtl/alarm_clock_controller.sv
// Top level of the 24-hour alarm clock controller: input register, update, result register.
// Each input word is one sampled pass of the control loop (second tick plus the up, down,
// set and enable buttons) and yields exactly one result word with the shown time, four
// active-low seven-segment codes, the decimal points, the mode flags and the alarm match.
// A word is accepted every clock while ready is high. The single-pass update runs while the
// word sits in the input register, and its result is loaded into the result register when that
// register is empty or being read. While the result register is stalled the input register
// still takes one more word; ready drops only when both hold a word.
module alarm_clock_controller (
  input  logic      clk,
  input  logic      rst,
  acc_in_if.sink    item,
  acc_out_if.source result
);
  import acc_pkg::*;

  logic        held_valid;
  acc_in_t     held_word;
  logic        res_valid;
  acc_out_t    res_word;
  logic        advance;
  acc_status_t status;
  acc_out_t    shown_word;

  assign advance    = held_valid && (!res_valid || result.ready);
  assign item.ready = !held_valid || advance;

  acc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (held_word),
    .status (status)
  );

  acc_display u_display (
    .status (status),
    .word   (shown_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.ready) begin
      held_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_word <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= shown_word;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_word;

endmodule
